FILE: rtl/core/bdns_pkg.sv
// Package for the binary descriptor nearest search block.
// Holds the word types, sizing constants and the bit count helpers; no dependencies.
`timescale 1ns / 1ps

package bdns_pkg;

    // Search sizing
    localparam int MAX_CANDIDATES = 4096;
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W          = 12;
    localparam int DIST_W         = 9;
    localparam int WORD_W         = 64;
    localparam int NUM_WORDS      = 4;
    localparam int DESC_W         = WORD_W * NUM_WORDS;
    localparam int REG_IDX_W      = 2;

    // Distance above any real one, marks an empty search
    localparam logic [DIST_W-1:0] NO_DISTANCE = DIST_W'(257);

    // Bit count split: 16 chunks of 16 bits
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = DESC_W / CHUNK_W;
    localparam int PART_W     = 5;

    // Decoupling queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // Input word
    typedef struct packed {
        logic              last_candidate;
        logic [WORD_W-1:0] cand_word_3;
        logic [WORD_W-1:0] cand_word_2;
        logic [WORD_W-1:0] cand_word_1;
        logic [WORD_W-1:0] cand_word_0;
    } cand_t;

    // Result word
    typedef struct packed {
        logic [DIST_W-1:0] nearest_dist;
        logic [IDX_W-1:0]  best_index;
        logic              too_many;
    } result_t;

    // Queue entry: a classified candidate
    typedef struct packed {
        logic [DIST_W-1:0] hamming;
        logic              last;
    } dist_t;

    // Set bits of a 16-bit chunk, as an adder tree
    function automatic logic [PART_W-1:0] popcnt16(input logic [CHUNK_W-1:0] v);
        logic [7:0][1:0] l1;
        logic [3:0][2:0] l2;
        logic [1:0][3:0] l3;
        for (int i = 0; i < 8; i++) begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

    // Sum of the 16 chunk counts, as an adder tree
    function automatic logic [DIST_W-1:0] sum16(
        input logic [NUM_CHUNKS-1:0][PART_W-1:0] p
    );
        logic [7:0][5:0] s1;
        logic [3:0][6:0] s2;
        logic [1:0][7:0] s3;
        for (int i = 0; i < 8; i++) begin
            s1[i] = {1'b0, p[2*i]} + {1'b0, p[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        return {1'b0, s3[0]} + {1'b0, s3[1]};
    endfunction

endpackage

FILE: rtl/core/bdns_front.sv
// Front end: query registers, candidate intake, XOR and two-stage bit count.
// Depends on bdns_pkg.
`timescale 1ns / 1ps

module bdns_front import bdns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cand_t                s_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output dist_t                q_data
);

    logic [NUM_WORDS-1:0][WORD_W-1:0]     query_reg;
    logic                                 a_valid_reg;
    logic [DESC_W-1:0]                    a_xor_reg;
    logic                                 a_last_reg;
    logic                                 b_valid_reg;
    logic [NUM_CHUNKS-1:0][PART_W-1:0]    b_cnt_reg;
    logic                                 b_last_reg;
    logic [NUM_CHUNKS-1:0][PART_W-1:0]    b_cnt_next;
    logic                                 adv_a;
    logic                                 adv_b;
    logic [DESC_W-1:0]                    cand_bits;

    // Query registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg <= '0;
        end else if (cfg_we) begin
            query_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Stall chain: each stage moves when the next one can take its word
    assign adv_b   = !b_valid_reg || q_ready;
    assign adv_a   = !a_valid_reg || adv_b;
    assign s_ready = adv_a;

    assign cand_bits = {s_item.cand_word_3, s_item.cand_word_2,
                        s_item.cand_word_1, s_item.cand_word_0};

    // Per-chunk counts of the differing bits
    always_comb begin
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            b_cnt_next[i] = popcnt16(a_xor_reg[i*CHUNK_W +: CHUNK_W]);
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (adv_a) a_valid_reg <= s_valid;
            if (adv_b) b_valid_reg <= a_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (adv_a) begin
            a_xor_reg  <= cand_bits ^ query_reg;
            a_last_reg <= s_item.last_candidate;
        end
        if (adv_b) begin
            b_cnt_reg  <= b_cnt_next;
            b_last_reg <= a_last_reg;
        end
    end

    // Final sum goes straight into the queue
    assign q_valid = b_valid_reg;
    assign q_data  = '{hamming: sum16(b_cnt_reg), last: b_last_reg};

endmodule

FILE: rtl/core/bdns_fifo.sv
// Short queue between the front end and the search back end.
// Depends on bdns_pkg.
`timescale 1ns / 1ps

module bdns_fifo import bdns_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  dist_t  wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output dist_t  rd_data
);

    dist_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  push;
    logic                  pop;

    assign wr_ready = (count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/core/bdns_back.sv
// Back end: running minimum, candidate count, overflow flag and result register.
// Depends on bdns_pkg.
`timescale 1ns / 1ps

module bdns_back import bdns_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  dist_t   q_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_item
);

    logic [DIST_W-1:0] min_reg;
    logic [DIST_W-1:0] min_next;
    logic [IDX_W-1:0]  best_reg;
    logic [IDX_W-1:0]  best_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              m_valid_reg;
    result_t           m_item_reg;
    logic              out_free;
    logic              pop;
    logic              in_range;

    // A last word needs the result slot; other words always go
    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !q_data.last || out_free;
    assign pop      = q_valid && q_ready;
    assign in_range = (cnt_reg < CNT_W'(MAX_CANDIDATES));

    // Search update for the word at the queue head
    always_comb begin
        min_next  = min_reg;
        best_next = best_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (in_range) begin
            if (q_data.hamming < min_reg) begin
                min_next  = q_data.hamming;
                best_next = cnt_reg[IDX_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
    end

    // Search state, cleared after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= NO_DISTANCE;
            best_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (pop) begin
            if (q_data.last) begin
                min_reg  <= NO_DISTANCE;
                best_reg <= '0;
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                min_reg  <= min_next;
                best_reg <= best_next;
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && q_data.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_data.last) begin
            m_item_reg.nearest_dist <= min_next;
            m_item_reg.best_index   <= best_next;
            m_item_reg.too_many     <= ovf_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: rtl/core/binary_descriptor_nearest_search.sv
// Top level of the binary descriptor nearest search.
// Depends on bdns_pkg, bdns_front, bdns_fifo and bdns_back.
`timescale 1ns / 1ps

// Hamming nearest-neighbor search over 256-bit descriptors. Write the query as four
// 64-bit words at register indexes 0..3 while the block is idle, then stream candidates,
// one word per cycle; the word with last_candidate set closes the search and produces
// one result (minimum distance, index of the first candidate at that distance, and an
// overflow flag if more than MAX_CANDIDATES words came in). Throughput is one candidate
// per clock unless a last word waits on an untaken result. An accepted candidate passes
// the XOR stage, the chunk bit count stage, then the final sum written into a four-entry
// queue, whose head the back end compares and, for a last word, loads into the result
// register. The queue lets the front end keep taking words while a result waits.
module binary_descriptor_nearest_search import bdns_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cand_t                s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_item
);

    logic  fq_valid;
    logic  fq_ready;
    dist_t fq_data;
    logic  qb_valid;
    logic  qb_ready;
    dist_t qb_data;

    bdns_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    bdns_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    bdns_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // A candidate distance never exceeds the descriptor width
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        qb_valid |-> (qb_data.hamming <= DIST_W'(DESC_W)))
        else $error("candidate distance out of range");

    // Every search compares at least one candidate, so a result holds a real distance
    a_result_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.nearest_dist <= DIST_W'(DESC_W)))
        else $error("result carries no distance");

    // The back end never closes a search while an unread result would be lost
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (qb_valid && qb_ready && qb_data.last) |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

    // A stalled front stage keeps its word valid until the queue takes it
    a_front_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (fq_valid && !fq_ready) |=> fq_valid)
        else $error("front stage dropped a word while stalled");

endmodule
